FILE: rtl/assert_macros.svh
// Assertion macros used by the checker core.
// Checks are compiled for simulation only and vanish in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks a property on every rising edge of clk while out of reset.
`define MBRFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks a property on every rising edge of clk, reset included.
`define MBRFC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MBRFC_ASSERT(lbl, prop, msg)
`define MBRFC_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

FILE: rtl/mbrfc_pkg.sv
package mbrfc_pkg;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_SHORT  = 2'd1,
    ST_LONG   = 2'd2,
    ST_BADCRC = 2'd3
  } status_t;

  // CRC-16/MODBUS constants.
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Frame layout, as byte positions and counts.
  localparam logic [3:0] FRAME_LEN   = 4'd7;
  localparam logic [3:0] CRC_BYTES   = 4'd5;
  localparam logic [3:0] COUNT_MAX   = 4'd8;
  localparam logic [3:0] POS_VAL_HI  = 4'd3;
  localparam logic [3:0] POS_VAL_LO  = 4'd4;
  localparam logic [3:0] POS_CRC_LO  = 4'd5;
  localparam logic [3:0] POS_CRC_HI  = 4'd6;

  // Register value reported on any error.
  localparam logic signed [15:0] VALUE_ERR = -16'sd1;

endpackage

FILE: rtl/mbrfc_if.sv
// Request channel carrying received reply bytes.
interface mbrfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       has_byte;
  logic       frame_end;

  modport source (output valid, rx_byte, has_byte, frame_end, input ready);
  modport sink   (input valid, rx_byte, has_byte, frame_end, output ready);
endinterface

// Result channel carrying one verdict per frame.
interface mbrfc_out_if;
  logic                  valid;
  logic                  ready;
  mbrfc_pkg::status_t    status;
  logic signed [15:0]    reg_value;

  modport source (output valid, status, reg_value, input ready);
  modport sink   (input valid, status, reg_value, output ready);
endinterface

FILE: rtl/mbrfc_crc_byte.sv
// Byte-wide CRC-16/MODBUS update: eight reflected shift steps unrolled.
module mbrfc_crc_byte (
  input  logic [15:0] crc_i,
  input  logic [7:0]  data_i,
  output logic [15:0] crc_o
);

  logic [15:0] c;

  // Fold the byte into the low end, then shift out one bit per step.
  always_comb begin
    c = crc_i ^ {8'h00, data_i};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ mbrfc_pkg::CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_o = c;
  end

endmodule

FILE: rtl/modbus_reply_frame_checker_core.sv
// Channel  Dir  Payload                              Handshake
// in_ch    in   rx_byte[7:0], has_byte, frame_end    valid/ready
// out_ch   out  status[1:0], reg_value[15:0] signed  valid/ready
//
// One request is taken every cycle unless a frame end is held back; the
// verdict for a frame passes the input register, then the result register.
// The byte-wide CRC update between the two registers sets the cycle time.
// Synchronous active-low reset clears the frame state and both valid flags.
// A stalled result holds back a request that ends a frame, and those behind it;
// other requests keep flowing into the frame state.
`include "assert_macros.svh"

module modbus_reply_frame_checker_core (
  input  logic              clk,
  input  logic              rst_n,
  mbrfc_in_if.sink          in_ch,
  mbrfc_out_if.source       out_ch
);

  // Input register.
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_has_r;
  logic       s1_end_r;

  // Frame state.
  logic [15:0] crc_acc_r;
  logic [3:0]  byte_count_r;
  logic [15:0] value_hold_r;
  logic [15:0] crc_rx_r;

  // Result register.
  logic                  out_valid_r;
  mbrfc_pkg::status_t    out_status_r;
  logic signed [15:0]    out_value_r;

  // Handshake control.
  logic out_free;
  logic s1_adv;
  logic s1_fire;
  logic in_ready;
  logic load_out;

  // Frame state after the current byte.
  logic [15:0]        crc_upd;
  logic [15:0]        crc_nxt;
  logic [3:0]         byte_count_nxt;
  logic [15:0]        value_hold_nxt;
  logic [15:0]        crc_rx_nxt;
  mbrfc_pkg::status_t status_nxt;
  logic signed [15:0] value_nxt;

  // The stage only waits when it holds a frame end and the result slot is full.
  assign out_free = !out_valid_r || out_ch.ready;
  assign s1_adv   = !s1_end_r || out_free;
  assign s1_fire  = s1_valid_r && s1_adv;
  assign in_ready = !s1_valid_r || s1_adv;
  assign load_out = s1_fire && s1_end_r;

  assign in_ch.ready = in_ready;

  // Capture each request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      s1_byte_r <= in_ch.rx_byte;
      s1_has_r  <= in_ch.has_byte;
      s1_end_r  <= in_ch.frame_end;
    end
  end

  mbrfc_crc_byte u_crc (
    .crc_i  (crc_acc_r),
    .data_i (s1_byte_r),
    .crc_o  (crc_upd)
  );

  // Fold the byte into the frame state.
  always_comb begin
    crc_nxt        = crc_acc_r;
    byte_count_nxt = byte_count_r;
    value_hold_nxt = value_hold_r;
    crc_rx_nxt     = crc_rx_r;
    if (s1_has_r) begin
      if (byte_count_r < mbrfc_pkg::CRC_BYTES) begin
        crc_nxt = crc_upd;
      end
      case (byte_count_r)
        mbrfc_pkg::POS_VAL_HI: value_hold_nxt[15:8] = s1_byte_r;
        mbrfc_pkg::POS_VAL_LO: value_hold_nxt[7:0]  = s1_byte_r;
        mbrfc_pkg::POS_CRC_LO: crc_rx_nxt[7:0]      = s1_byte_r;
        mbrfc_pkg::POS_CRC_HI: crc_rx_nxt[15:8]     = s1_byte_r;
        default: ;
      endcase
      if (byte_count_r < mbrfc_pkg::COUNT_MAX) begin
        byte_count_nxt = byte_count_r + 4'd1;
      end
    end
  end

  // Verdict for a frame that ends with this request.
  always_comb begin
    if (byte_count_nxt > mbrfc_pkg::FRAME_LEN) begin
      status_nxt = mbrfc_pkg::ST_LONG;
    end else if (byte_count_nxt < mbrfc_pkg::FRAME_LEN) begin
      status_nxt = mbrfc_pkg::ST_SHORT;
    end else if (crc_rx_nxt != crc_nxt) begin
      status_nxt = mbrfc_pkg::ST_BADCRC;
    end else begin
      status_nxt = mbrfc_pkg::ST_OK;
    end
    value_nxt = (status_nxt == mbrfc_pkg::ST_OK) ? $signed(value_hold_nxt)
                                                 : mbrfc_pkg::VALUE_ERR;
  end

  // Frame state: cleared at frame end, otherwise updated per request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_acc_r    <= mbrfc_pkg::CRC_INIT;
      byte_count_r <= '0;
      value_hold_r <= '0;
      crc_rx_r     <= '0;
    end else if (s1_fire) begin
      if (s1_end_r) begin
        crc_acc_r    <= mbrfc_pkg::CRC_INIT;
        byte_count_r <= '0;
        value_hold_r <= '0;
        crc_rx_r     <= '0;
      end else begin
        crc_acc_r    <= crc_nxt;
        byte_count_r <= byte_count_nxt;
        value_hold_r <= value_hold_nxt;
        crc_rx_r     <= crc_rx_nxt;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r <= status_nxt;
      out_value_r  <= value_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.reg_value = out_value_r;

  // Checks.
  `MBRFC_ASSERT(a_count_sat, byte_count_r <= mbrfc_pkg::COUNT_MAX, "byte count above saturation")
  `MBRFC_ASSERT(a_err_value, (out_valid_r && out_status_r != mbrfc_pkg::ST_OK) |-> (out_value_r == mbrfc_pkg::VALUE_ERR), "error result without -1 value")
  `MBRFC_ASSERT(a_frame_clear, load_out |=> (byte_count_r == 4'd0 && crc_acc_r == mbrfc_pkg::CRC_INIT), "frame state not cleared after frame end")
  `MBRFC_ASSERT(a_end_stall, (out_valid_r && !out_ch.ready && s1_valid_r && s1_end_r) |-> !in_ch.ready, "request taken while a frame end is blocked")

endmodule

FILE: bench/tb_modbus_reply_frame_checker_core.sv
module tb_modbus_reply_frame_checker_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_PERCENT   = 34;
  localparam int RANDOM_ITEMS   = 1350;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 10;

  typedef logic [7:0] byte_q_t[$];

  typedef struct {
    mbrfc_pkg::status_t status;
    logic signed [15:0] value;
  } verdict_t;

  // Mirrors the frame state of the checker and keeps the verdicts still owed.
  class verdict_board;
    logic [15:0] crc_run;
    logic [3:0]  nbytes;
    logic [15:0] held_value;
    logic [15:0] crc_seen;
    verdict_t    owed_q[$];
    int          errors;

    function new();
      errors = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      crc_run    = mbrfc_pkg::CRC_INIT;
      nbytes     = '0;
      held_value = '0;
      crc_seen   = '0;
    endfunction

    // Byte-wide CRC-16/MODBUS step, LSB first.
    static function logic [15:0] crc_update(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      r = c ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
        r = r[0] ? ((r >> 1) ^ mbrfc_pkg::CRC_POLY) : (r >> 1);
      end
      return r;
    endfunction

    // Folds one accepted request into the frame state.
    function void note_request(logic [7:0] b, logic has, logic fend);
      verdict_t v;
      if (has) begin
        if (nbytes < mbrfc_pkg::CRC_BYTES) crc_run = crc_update(crc_run, b);
        case (nbytes)
          mbrfc_pkg::POS_VAL_HI: held_value[15:8] = b;
          mbrfc_pkg::POS_VAL_LO: held_value[7:0]  = b;
          mbrfc_pkg::POS_CRC_LO: crc_seen[7:0]    = b;
          mbrfc_pkg::POS_CRC_HI: crc_seen[15:8]   = b;
          default: ;
        endcase
        if (nbytes < mbrfc_pkg::COUNT_MAX) nbytes = nbytes + 4'd1;
      end
      if (fend) begin
        if (nbytes > mbrfc_pkg::FRAME_LEN) v.status = mbrfc_pkg::ST_LONG;
        else if (nbytes < mbrfc_pkg::FRAME_LEN) v.status = mbrfc_pkg::ST_SHORT;
        else if (crc_seen != crc_run) v.status = mbrfc_pkg::ST_BADCRC;
        else v.status = mbrfc_pkg::ST_OK;
        v.value = (v.status == mbrfc_pkg::ST_OK) ? held_value : mbrfc_pkg::VALUE_ERR;
        owed_q.push_back(v);
        clear_frame();
      end
    endfunction

    // Compares a delivered verdict with the oldest one owed.
    function void check_verdict(mbrfc_pkg::status_t st, logic signed [15:0] value);
      verdict_t v;
      if (owed_q.size() == 0) begin
        $error("unexpected verdict: status %0d reg_value %0d", st, value);
        errors++;
        return;
      end
      v = owed_q.pop_front();
      if (st !== v.status) begin
        $error("status: expected %0d, got %0d", v.status, st);
        errors++;
      end
      if (value !== v.value) begin
        $error("reg_value: expected %0d, got %0d", v.value, value);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic no_idle;
  int   item_count;
  int   quiet_cycles;

  verdict_board board = new();

  mbrfc_in_if  in_ch();
  mbrfc_out_if out_ch();

  modbus_reply_frame_checker_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Random back-pressure on the verdict channel.
  always @(posedge clk) begin
    out_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
  end

  // Monitor both channels and watch for a stuck handshake. A verdict taken
  // at this edge always belongs to an earlier request, so it is checked first.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) board.check_verdict(out_ch.status, out_ch.reg_value);
      if (in_ch.valid && in_ch.ready)
        board.note_request(in_ch.rx_byte, in_ch.has_byte, in_ch.frame_end);
      if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offers one request, with random idle cycles ahead of it, and waits for it
  // to be taken.
  task automatic send_request(logic [7:0] b, logic has, logic fend);
    while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.rx_byte   <= b;
    in_ch.has_byte  <= has;
    in_ch.frame_end <= fend;
    do @(posedge clk); while (!in_ch.ready);
    if (has || fend) item_count++;
  endtask

  // Sends a reply byte by byte, with the odd empty request in between, and
  // ends it either on the last byte or with a request of its own.
  task automatic send_reply(byte_q_t bytes, bit end_on_last, int gap_percent);
    for (int i = 0; i < bytes.size(); i++) begin
      if ($urandom_range(99) < gap_percent) send_request(8'($urandom), 1'b0, 1'b0);
      send_request(bytes[i], 1'b1, end_on_last && (i == bytes.size() - 1));
    end
    if (!end_on_last || bytes.size() == 0) send_request(8'($urandom), 1'b0, 1'b1);
  endtask

  // Holds the sender back until every owed verdict has come.
  task automatic wait_verdicts_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.owed_q.size() != 0) @(posedge clk);
  endtask

  // A well-formed read reply carrying one register; a corrupted one has a
  // single bit flipped, which the CRC always catches.
  function automatic byte_q_t build_reply(logic [7:0] addr, logic [7:0] func,
                                          logic [15:0] value, bit corrupt);
    byte_q_t     q;
    logic [15:0] crc;
    q   = '{addr, func, 8'h02, value[15:8], value[7:0]};
    crc = mbrfc_pkg::CRC_INIT;
    foreach (q[i]) crc = verdict_board::crc_update(crc, q[i]);
    q.push_back(crc[7:0]);
    q.push_back(crc[15:8]);
    if (corrupt) q[$urandom_range(6)] ^= 8'(1 << $urandom_range(7));
    return q;
  endfunction

  function automatic byte_q_t random_bytes(int count);
    byte_q_t q;
    for (int i = 0; i < count; i++) q.push_back(8'($urandom));
    return q;
  endfunction

  initial begin
    byte_q_t frame;
    int      pick;
    int      frame_no;

    rst_n           = 1'b0;
    no_idle         = 1'b0;
    item_count      = 0;
    quiet_cycles    = 0;
    in_ch.valid     = 1'b0;
    in_ch.rx_byte   = '0;
    in_ch.has_byte  = 1'b0;
    in_ch.frame_end = 1'b0;
    out_ch.ready    = 1'b0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: frame end with no bytes straight after reset.
    send_request(8'h00, 1'b0, 1'b1);
    // Good reply with the most negative value, ended on its last byte.
    send_reply(build_reply(8'hFF, 8'h04, 16'h8000, 1'b0), 1'b1, 0);
    // An empty request has no effect.
    send_request(8'hFF, 1'b0, 1'b0);
    // Bad CRC on the most positive value, ended by a separate request whose
    // byte must be ignored.
    frame = build_reply(8'h00, 8'h03, 16'h7FFF, 1'b0);
    frame[6] ^= 8'h80;
    send_reply(frame, 1'b0, 0);
    // Short frame of a single byte.
    send_reply('{8'hFF}, 1'b1, 0);
    // Long frame: the count saturates and the extra bytes are not stored.
    frame = build_reply(8'h01, 8'h04, 16'h0000, 1'b0);
    frame.push_back(8'h00);
    frame.push_back(8'hFF);
    send_reply(frame, 1'b1, 0);
    wait_verdicts_drained();

    // Random part: mostly well-formed replies, mixed with damaged, short, long
    // and plain noise frames.
    item_count = 0;
    frame_no   = 0;
    while (item_count < RANDOM_ITEMS) begin
      no_idle = (frame_no >= 70 && frame_no < 110);
      pick    = $urandom_range(99);
      if (pick < 55)
        frame = build_reply(8'($urandom), 8'($urandom), 16'($urandom), 1'b0);
      else if (pick < 70)
        frame = build_reply(8'($urandom), 8'($urandom), 16'($urandom), 1'b1);
      else if (pick < 80)
        frame = random_bytes($urandom_range(6));
      else if (pick < 90) begin
        frame = build_reply(8'($urandom), 8'($urandom), 16'($urandom), 1'b0);
        repeat ($urandom_range(5, 1)) frame.push_back(8'($urandom));
      end else
        frame = random_bytes($urandom_range(12));
      send_reply(frame, 1'($urandom_range(1)), 8);
      if (frame_no == 40) wait_verdicts_drained();
      frame_no++;
    end
    no_idle = 1'b0;

    wait_verdicts_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.owed_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      if (board.owed_q.size() != 0) $error("%0d verdicts never arrived", board.owed_q.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
